// ===== hw/rtl/cab_pkg.sv =====
// cab_pkg: shared types and constants for the clipped alpha blend pixel unit
// no dependencies; imported by cab_chan and clipped_alpha_blend_pixel_top

package cab_pkg;

  // field widths fixed by the pixel format and register map
  localparam int unsigned CoordInW  = 16;
  localparam int unsigned RegW      = 14;
  localparam int unsigned AddrW     = 26;
  localparam int unsigned ChanW     = 8;
  localparam int unsigned CfgIdxW   = 2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SCREEN_HEIGHT = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_LINE_PITCH    = 2'd2;

  // register reset values
  localparam logic [RegW-1:0] WIDTH_RST  = 14'd1024;
  localparam logic [RegW-1:0] HEIGHT_RST = 14'd768;
  localparam logic [RegW-1:0] PITCH_RST  = 14'd1024;

  // alpha codes with a fixed result
  localparam logic [ChanW-1:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [ChanW-1:0] ALPHA_CLEAR  = 8'h00;
  localparam logic [31:0]      RGB_MASK     = 32'h00FF_FFFF;

  typedef struct packed {
    logic signed [CoordInW-1:0] pos_x;
    logic signed [CoordInW-1:0] pos_y;
    logic [31:0]                dest_pixel;
    logic [31:0]                source_color;
  } cab_in_t;

  typedef struct packed {
    logic             write_enable;
    logic [AddrW-1:0] word_address;
    logic [31:0]      blended_pixel;
  } cab_out_t;

  // load enables of the three pipeline stages
  typedef struct packed {
    logic en1;
    logic en2;
    logic en3;
  } cab_stage_en_t;

endpackage

// ===== hw/rtl/cab_chan.sv =====
// cab_chan: three-stage pipeline for one color channel, (s*a + d*(255-a)) / 255
// depends on cab_pkg for widths and the stage enable struct

module cab_chan import cab_pkg::*; (
  input  logic              clk_i,
  input  cab_stage_en_t     stage_en_i,
  input  logic [ChanW-1:0]  src_i,
  input  logic [ChanW-1:0]  dst_i,
  input  logic [ChanW-1:0]  alpha_i,
  output logic [ChanW-1:0]  chan_o
);

  localparam int unsigned ProdW = 2 * ChanW;

  logic [ProdW-1:0] src_prod_q, dst_prod_q;
  logic [ProdW-1:0] sum_d, sum_q;
  logic [ProdW:0]   quot_sum;
  logic [ChanW-1:0] chan_d, chan_q;

  // stage 1: the two weighted products
  always_ff @(posedge clk_i) begin
    if (stage_en_i.en1) begin
      src_prod_q <= ProdW'(src_i) * ProdW'(alpha_i);
      dst_prod_q <= ProdW'(dst_i) * ProdW'(ALPHA_OPAQUE - alpha_i);
    end
  end

  // stage 2: sum, at most 255*255 so it fits 16 bits
  assign sum_d = src_prod_q + dst_prod_q;

  always_ff @(posedge clk_i) begin
    if (stage_en_i.en2) begin
      sum_q <= sum_d;
    end
  end

  // stage 3: exact divide by 255 for n below 2^16: (n + (n >> 8) + 1) >> 8
  assign quot_sum = (ProdW+1)'(sum_q) + (ProdW+1)'(sum_q >> ChanW) + (ProdW+1)'(1);
  assign chan_d   = quot_sum[ChanW +: ChanW];

  always_ff @(posedge clk_i) begin
    if (stage_en_i.en3) begin
      chan_q <= chan_d;
    end
  end

  assign chan_o = chan_q;

endmodule

// ===== hw/rtl/clipped_alpha_blend_pixel_top.sv =====
// clipped_alpha_blend_pixel_top: clip, address and source-over blend for one pixel
// depends on cab_pkg and cab_chan
//
//   port group   direction  handshake                  payload
//   in_*         input      in_valid_i / in_stall_o    cab_in_t  in_data_i
//   out_*        output     out_valid_o / out_stall_i  cab_out_t out_data_o
//   cfg_*        input      cfg_we_i                   cfg_idx_i, cfg_wdata_i
//
// three register stages: products, sums, divide; the last one is the output
// register, and the result select reads it combinationally
// one item per clock sustained while out_stall_i is low; stage 1 multipliers (y*pitch and 8x8 per channel) set depth
// a stalled output only holds the stages behind it that are full; bubbles close up
// reset clears the valid bits and loads 1024, 768, 1024 into width, height and pitch

module clipped_alpha_blend_pixel_top import cab_pkg::*; #(
  parameter int unsigned COORD_BITS = 13
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  cab_in_t            in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output cab_out_t           out_data_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [RegW-1:0]    cfg_wdata_i
);

  localparam int unsigned ProdW = COORD_BITS + RegW;
  localparam int unsigned SumW  = (ProdW > AddrW) ? ProdW : AddrW;

  logic [RegW-1:0] width_q, height_q, pitch_q;
  logic            v1_q, v2_q, v3_q;
  cab_stage_en_t   stage_en;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      pitch_q  <= PITCH_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SCREEN_WIDTH:  width_q  <= cfg_wdata_i;
        CFG_SCREEN_HEIGHT: height_q <= cfg_wdata_i;
        CFG_LINE_PITCH:    pitch_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // stage enables: a stage loads when it is empty or the one after it moves
  always_comb begin
    stage_en.en3 = !v3_q || !out_stall_i;
    stage_en.en2 = !v2_q || stage_en.en3;
    stage_en.en1 = !v1_q || stage_en.en2;
  end

  assign in_stall_o = !stage_en.en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (stage_en.en1) v1_q <= in_valid_i;
      if (stage_en.en2) v2_q <= v1_q;
      if (stage_en.en3) v3_q <= v2_q;
    end
  end

  // clip: non-negative, below 2^COORD_BITS and below the register
  logic [CoordInW-1:0] x_raw, y_raw;
  logic                x_in, y_in, inside_d;

  assign x_raw = in_data_i.pos_x;
  assign y_raw = in_data_i.pos_y;
  assign x_in  = !x_raw[CoordInW-1] && ((x_raw >> COORD_BITS) == '0)
                 && (x_raw < CoordInW'(width_q));
  assign y_in  = !y_raw[CoordInW-1] && ((y_raw >> COORD_BITS) == '0)
                 && (y_raw < CoordInW'(height_q));
  assign inside_d = x_in && y_in;

  // words for the alpha codes that skip the blend
  logic [ChanW-1:0] alpha;
  logic             bypass_d;
  logic [31:0]      byp_word_d;

  assign alpha      = in_data_i.source_color[31:24];
  assign bypass_d   = (alpha == ALPHA_OPAQUE) || (alpha == ALPHA_CLEAR);
  assign byp_word_d = (alpha == ALPHA_OPAQUE) ? (in_data_i.source_color & RGB_MASK)
                                              : in_data_i.dest_pixel;

  // stage 1: row product and clip flag
  logic                  inside1_q, bypass1_q;
  logic [31:0]           byp_word1_q;
  logic [COORD_BITS-1:0] x1_q;
  logic [ProdW-1:0]      row_prod1_q;

  always_ff @(posedge clk_i) begin
    if (stage_en.en1) begin
      inside1_q   <= inside_d;
      bypass1_q   <= bypass_d;
      byp_word1_q <= byp_word_d;
      x1_q        <= x_raw[COORD_BITS-1:0];
      row_prod1_q <= ProdW'(y_raw[COORD_BITS-1:0]) * ProdW'(pitch_q);
    end
  end

  // stage 2: word address, wraps at 2^26
  logic [SumW-1:0]  addr_sum;
  logic             inside2_q, bypass2_q;
  logic [31:0]      byp_word2_q;
  logic [AddrW-1:0] addr2_q;

  assign addr_sum = SumW'(row_prod1_q) + SumW'(x1_q);

  always_ff @(posedge clk_i) begin
    if (stage_en.en2) begin
      inside2_q   <= inside1_q;
      bypass2_q   <= bypass1_q;
      byp_word2_q <= byp_word1_q;
      addr2_q     <= addr_sum[AddrW-1:0];
    end
  end

  // stage 3: carried to the output register
  logic             inside3_q, bypass3_q;
  logic [31:0]      byp_word3_q;
  logic [AddrW-1:0] addr3_q;

  always_ff @(posedge clk_i) begin
    if (stage_en.en3) begin
      inside3_q   <= inside2_q;
      bypass3_q   <= bypass2_q;
      byp_word3_q <= byp_word2_q;
      addr3_q     <= addr2_q;
    end
  end

  // per channel blend pipelines, red, green, blue
  logic [ChanW-1:0] red, green, blue;

  cab_chan u_chan_r (
    .clk_i      (clk_i),
    .stage_en_i (stage_en),
    .src_i      (in_data_i.source_color[23:16]),
    .dst_i      (in_data_i.dest_pixel[23:16]),
    .alpha_i    (alpha),
    .chan_o     (red)
  );

  cab_chan u_chan_g (
    .clk_i      (clk_i),
    .stage_en_i (stage_en),
    .src_i      (in_data_i.source_color[15:8]),
    .dst_i      (in_data_i.dest_pixel[15:8]),
    .alpha_i    (alpha),
    .chan_o     (green)
  );

  cab_chan u_chan_b (
    .clk_i      (clk_i),
    .stage_en_i (stage_en),
    .src_i      (in_data_i.source_color[7:0]),
    .dst_i      (in_data_i.dest_pixel[7:0]),
    .alpha_i    (alpha),
    .chan_o     (blue)
  );

  // result select; clipped pixels give all zero fields
  always_comb begin
    out_data_o.write_enable = inside3_q;
    out_data_o.word_address = inside3_q ? addr3_q : '0;
    if (!inside3_q) begin
      out_data_o.blended_pixel = '0;
    end else if (bypass3_q) begin
      out_data_o.blended_pixel = byp_word3_q;
    end else begin
      out_data_o.blended_pixel = {8'h00, red, green, blue};
    end
  end

  assign out_valid_o = v3_q;

  // input stalls only when every stage is full and the output is held
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (v1_q && v2_q && v3_q && out_stall_i))
    else $error("input stalled with a free stage");

  // a held result stays in the output stage
  a_hold_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && out_stall_i) |=> v3_q)
    else $error("stalled result dropped");

  // an accepted item lands in stage 1
  a_accept_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> v1_q)
    else $error("accepted item lost at stage 1");

  // a nonzero top byte only comes from a clear-alpha pass of the destination
  a_top_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && (out_data_o.blended_pixel[31:24] != 8'h00)) |-> (inside3_q && bypass3_q))
    else $error("top byte set on a blended word");

endmodule
